/* src/touch_sample_average_and_map_macros.svh */
// Assertion helpers for the checker file of this block.
// Both sample on the rising edge of clock and stay quiet while reset is high.
`ifndef TOUCH_SAMPLE_AVERAGE_AND_MAP_MACROS_SVH
`define TOUCH_SAMPLE_AVERAGE_AND_MAP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSAM_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tsam check failed");

// The consequent must hold in the cycle after the antecedent.
`define TSAM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tsam check failed");

`endif

/* src/tsam_pkg.sv */
`timescale 1ns / 1ps

package tsam_pkg;

   localparam int CODE_W     = 13;
   localparam int SUM_W      = 16;
   localparam int CNT_W      = 4;
   localparam int PIX_W      = 8;
   localparam int DIM_W      = 9;
   localparam int CODE_SHIFT = 3;
   localparam int CSR_IDX_W  = 3;

   // Shared divider: the widest dividend is a 13-bit offset times a 9-bit scale.
   localparam int DIVIDEND_W = CODE_W + DIM_W;
   localparam int DIVISOR_W  = CODE_W;
   localparam int DIV_STEPS  = DIVIDEND_W;
   localparam int STEP_W     = $clog2(DIV_STEPS);

   localparam logic [CNT_W-1:0]  MAX_AVG        = 4'd8;
   localparam logic [CNT_W-1:0]  DEFAULT_AVG    = 4'd6;
   localparam logic [CODE_W-1:0] RAW_CALIB_MIN  = 13'd300;
   localparam logic [CODE_W-1:0] RAW_CALIB_MAX  = 13'd3800;
   localparam logic [DIM_W-1:0]  DEFAULT_WIDTH  = 9'd160;
   localparam logic [DIM_W-1:0]  DEFAULT_HEIGHT = 9'd128;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RAW_X_MIN     = 3'd0,
      CSR_RAW_X_MAX     = 3'd1,
      CSR_RAW_Y_MIN     = 3'd2,
      CSR_RAW_Y_MAX     = 3'd3,
      CSR_SCREEN_WIDTH  = 3'd4,
      CSR_SCREEN_HEIGHT = 3'd5,
      CSR_AVG_COUNT     = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      EV_NONE    = 2'd0,
      EV_PRESS   = 2'd1,
      EV_MOVE    = 2'd2,
      EV_RELEASE = 2'd3
   } touch_event_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_AVG_X,
      ST_AVG_Y,
      ST_MAP_X,
      ST_MAP_Y
   } seq_state_type;

   typedef struct packed {
      logic [CODE_W-1:0] raw_x_min;
      logic [CODE_W-1:0] raw_x_max;
      logic [CODE_W-1:0] raw_y_min;
      logic [CODE_W-1:0] raw_y_max;
      logic [DIM_W-1:0]  screen_width;
      logic [DIM_W-1:0]  screen_height;
      logic [CNT_W-1:0]  avg_count;
   } cfg_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
   } div_rsp_type;

endpackage

/* src/tsam_div.sv */
`timescale 1ns / 1ps

module tsam_div (
   input  logic                  clock,
   input  logic                  reset,
   input  tsam_pkg::div_req_type div_req,
   output tsam_pkg::div_rsp_type div_rsp
);
   import tsam_pkg::*;

   // Restoring division, one quotient bit per cycle, MSB first.
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  dsr_ff, dsr_in;

   logic [DIVISOR_W:0] trial;
   logic [DIVISOR_W:0] diff;
   logic               fits;

   always_comb begin
      trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
      diff  = trial - {1'b0, dsr_ff};
      fits  = (trial >= {1'b0, dsr_ff});

      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;

      if (div_req.start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(DIV_STEPS - 1);
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dsr_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

/* src/tsam_core.sv */
`timescale 1ns / 1ps

module tsam_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  tsam_pkg::cfg_type                     cfg,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_pen_down,
   input  logic [7:0]                            req_x_byte_hi,
   input  logic [7:0]                            req_x_byte_lo,
   input  logic [7:0]                            req_y_byte_hi,
   input  logic [7:0]                            req_y_byte_lo,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [tsam_pkg::PIX_W-1:0]            rsp_point_x,
   output logic [tsam_pkg::PIX_W-1:0]            rsp_point_y,
   output logic                                  rsp_is_pressed,
   output logic [1:0]                            rsp_touch_event,
   output tsam_pkg::div_req_type                 div_req,
   input  tsam_pkg::div_rsp_type                 div_rsp
);
   import tsam_pkg::*;

   seq_state_type   state_ff, state_in;
   logic [SUM_W-1:0]  sum_x_ff, sum_x_in;
   logic [SUM_W-1:0]  sum_y_ff, sum_y_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [PIX_W-1:0]  last_x_ff, last_x_in;
   logic [PIX_W-1:0]  last_y_ff, last_y_in;
   logic              was_ff, was_in;
   logic [CODE_W-1:0] avg_x_ff, avg_x_in;

   logic                  start_ff, start_in;
   logic [DIVIDEND_W-1:0] dividend_ff, dividend_in;
   logic [DIVISOR_W-1:0]  divisor_ff, divisor_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0] rsp_x_ff, rsp_x_in;
   logic [PIX_W-1:0] rsp_y_ff, rsp_y_in;
   logic             rsp_pressed_ff, rsp_pressed_in;
   touch_event_type  rsp_event_ff, rsp_event_in;

   logic              req_xfer;
   logic [CODE_W-1:0] code_x, code_y;
   logic [SUM_W-1:0]  sum_x_add, sum_y_add;
   logic [CNT_W-1:0]  cnt_add;
   logic [CNT_W-1:0]  n_eff;
   logic              avg_full;
   logic [DIM_W-1:0]  top_w, top_h;
   div_req_type       map_x_req, map_y_req;

   // Largest pixel index for a screen dimension; a zero dimension acts as one.
   function automatic logic [DIM_W-1:0] top_of(input logic [DIM_W-1:0] dim);
      return (dim == '0) ? '0 : dim - 1'b1;
   endfunction

   // Clamps v into the window and forms the division that maps it.
   // An empty window divides zero by one, so the result is the top edge.
   function automatic div_req_type map_op(input logic [CODE_W-1:0] v,
                                          input logic [CODE_W-1:0] lo,
                                          input logic [CODE_W-1:0] hi,
                                          input logic [DIM_W-1:0]  top);
      div_req_type       op;
      logic [CODE_W-1:0] vc;
      logic [CODE_W-1:0] offset;
      op.start = 1'b1;
      if (hi <= lo) begin
         op.dividend = '0;
         op.divisor  = DIVISOR_W'(1);
      end else begin
         vc          = (v < lo) ? lo : ((v > hi) ? hi : v);
         offset      = vc - lo;
         op.dividend = DIVIDEND_W'(offset) * DIVIDEND_W'(top);
         op.divisor  = hi - lo;
      end
      return op;
   endfunction

   function automatic logic [PIX_W-1:0] finish(input logic [DIM_W-1:0]      top,
                                               input logic [DIVIDEND_W-1:0] q);
      logic [DIM_W-1:0] r;
      r = top - q[DIM_W-1:0];
      return r[DIM_W-1] ? {PIX_W{1'b1}} : r[PIX_W-1:0];
   endfunction

   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_xfer  = req_valid && !req_stall;

   assign code_x    = CODE_W'({req_x_byte_hi, req_x_byte_lo} >> CODE_SHIFT);
   assign code_y    = CODE_W'({req_y_byte_hi, req_y_byte_lo} >> CODE_SHIFT);
   assign sum_x_add = sum_x_ff + SUM_W'(code_x);
   assign sum_y_add = sum_y_ff + SUM_W'(code_y);
   assign cnt_add   = cnt_ff + 1'b1;
   assign n_eff     = (cfg.avg_count == '0) ? CNT_W'(1) :
                      ((cfg.avg_count > MAX_AVG) ? MAX_AVG : cfg.avg_count);
   assign avg_full  = (cnt_add >= n_eff);
   assign top_w     = top_of(cfg.screen_width);
   assign top_h     = top_of(cfg.screen_height);

   // Screen x comes from the raw y average, screen y from the raw x average.
   assign map_y_req = map_op(div_rsp.quotient[CODE_W-1:0], cfg.raw_y_min, cfg.raw_y_max,
                             top_w);
   assign map_x_req = map_op(avg_x_ff, cfg.raw_x_min, cfg.raw_x_max, top_h);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer && req_pen_down && avg_full) begin
               state_in = ST_AVG_X;
            end
         end
         ST_AVG_X: begin
            if (div_rsp.done) begin
               state_in = ST_AVG_Y;
            end
         end
         ST_AVG_Y: begin
            if (div_rsp.done) begin
               state_in = ST_MAP_X;
            end
         end
         ST_MAP_X: begin
            if (div_rsp.done) begin
               state_in = ST_MAP_Y;
            end
         end
         ST_MAP_Y: begin
            if (div_rsp.done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      sum_x_in       = sum_x_ff;
      sum_y_in       = sum_y_ff;
      cnt_in         = cnt_ff;
      last_x_in      = last_x_ff;
      last_y_in      = last_y_ff;
      was_in         = was_ff;
      avg_x_in       = avg_x_ff;
      start_in       = 1'b0;
      dividend_in    = dividend_ff;
      divisor_in     = divisor_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_x_in       = rsp_x_ff;
      rsp_y_in       = rsp_y_ff;
      rsp_pressed_in = rsp_pressed_ff;
      rsp_event_in   = rsp_event_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (!req_pen_down) begin
                  sum_x_in       = '0;
                  sum_y_in       = '0;
                  cnt_in         = '0;
                  was_in         = 1'b0;
                  rsp_valid_in   = 1'b1;
                  rsp_x_in       = last_x_ff;
                  rsp_y_in       = last_y_ff;
                  rsp_pressed_in = 1'b0;
                  rsp_event_in   = was_ff ? EV_RELEASE : EV_NONE;
               end else begin
                  sum_x_in = sum_x_add;
                  sum_y_in = sum_y_add;
                  cnt_in   = cnt_add;
                  if (avg_full) begin
                     start_in    = 1'b1;
                     dividend_in = DIVIDEND_W'(sum_x_add);
                     divisor_in  = DIVISOR_W'(cnt_add);
                  end
               end
            end
         end
         ST_AVG_X: begin
            if (div_rsp.done) begin
               avg_x_in    = div_rsp.quotient[CODE_W-1:0];
               start_in    = 1'b1;
               dividend_in = DIVIDEND_W'(sum_y_ff);
               divisor_in  = DIVISOR_W'(cnt_ff);
            end
         end
         ST_AVG_Y: begin
            if (div_rsp.done) begin
               start_in    = map_y_req.start;
               dividend_in = map_y_req.dividend;
               divisor_in  = map_y_req.divisor;
            end
         end
         ST_MAP_X: begin
            if (div_rsp.done) begin
               last_x_in   = finish(top_w, div_rsp.quotient);
               start_in    = map_x_req.start;
               dividend_in = map_x_req.dividend;
               divisor_in  = map_x_req.divisor;
            end
         end
         ST_MAP_Y: begin
            if (div_rsp.done) begin
               last_y_in      = finish(top_h, div_rsp.quotient);
               sum_x_in       = '0;
               sum_y_in       = '0;
               cnt_in         = '0;
               was_in         = 1'b1;
               rsp_valid_in   = 1'b1;
               rsp_x_in       = last_x_ff;
               rsp_y_in       = finish(top_h, div_rsp.quotient);
               rsp_pressed_in = 1'b1;
               rsp_event_in   = was_ff ? EV_MOVE : EV_PRESS;
            end
         end
         default: begin
            start_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_x_ff     <= '0;
         sum_y_ff     <= '0;
         cnt_ff       <= '0;
         last_x_ff    <= '0;
         last_y_ff    <= '0;
         was_ff       <= 1'b0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_x_ff     <= sum_x_in;
         sum_y_ff     <= sum_y_in;
         cnt_ff       <= cnt_in;
         last_x_ff    <= last_x_in;
         last_y_ff    <= last_y_in;
         was_ff       <= was_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      avg_x_ff       <= avg_x_in;
      dividend_ff    <= dividend_in;
      divisor_ff     <= divisor_in;
      rsp_x_ff       <= rsp_x_in;
      rsp_y_ff       <= rsp_y_in;
      rsp_pressed_ff <= rsp_pressed_in;
      rsp_event_ff   <= rsp_event_in;
   end

   assign div_req.start    = start_ff;
   assign div_req.dividend = dividend_ff;
   assign div_req.divisor  = divisor_ff;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_point_x     = rsp_x_ff;
   assign rsp_point_y     = rsp_y_ff;
   assign rsp_is_pressed  = rsp_pressed_ff;
   assign rsp_touch_event = rsp_event_ff;

endmodule

/* src/touch_sample_average_and_map.sv */
// Channel   Direction  Handshake           Payload
// req       in         req_valid/req_stall pen_down, x_byte_hi/lo, y_byte_hi/lo
// rsp       out        rsp_valid/rsp_stall point_x, point_y, is_pressed, touch_event
// csr       in         csr_write_en        csr_index, csr_wdata (write only)
//
// A pen-up transfer gives its result in the next cycle; one that only adds to the
// running sums frees the input at once. One that completes an average gives its
// result after four divisions (two averages, two mappings) of 22 quotient steps
// each, with req_stall held high.
// Reset is synchronous and active high; it restores the calibration defaults.
// A finished result waits in the output register while rsp_stall is high and stalls req.
`timescale 1ns / 1ps

module touch_sample_average_and_map (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_pen_down,
   input  logic [7:0]                         req_x_byte_hi,
   input  logic [7:0]                         req_x_byte_lo,
   input  logic [7:0]                         req_y_byte_hi,
   input  logic [7:0]                         req_y_byte_lo,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [7:0]                         rsp_point_x,
   output logic [7:0]                         rsp_point_y,
   output logic                               rsp_is_pressed,
   output logic [1:0]                         rsp_touch_event,
   input  logic                               csr_write_en,
   input  logic [tsam_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tsam_pkg::CODE_W-1:0]        csr_wdata
);
   import tsam_pkg::*;

   // Calibration registers. Each write keeps the low bits that the register
   // holds; an index past the last register is ignored.
   cfg_type     cfg_ff, cfg_in;
   div_req_type div_req;
   div_rsp_type div_rsp;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_RAW_X_MIN:     cfg_in.raw_x_min     = csr_wdata;
            CSR_RAW_X_MAX:     cfg_in.raw_x_max     = csr_wdata;
            CSR_RAW_Y_MIN:     cfg_in.raw_y_min     = csr_wdata;
            CSR_RAW_Y_MAX:     cfg_in.raw_y_max     = csr_wdata;
            CSR_SCREEN_WIDTH:  cfg_in.screen_width  = csr_wdata[DIM_W-1:0];
            CSR_SCREEN_HEIGHT: cfg_in.screen_height = csr_wdata[DIM_W-1:0];
            CSR_AVG_COUNT:     cfg_in.avg_count     = csr_wdata[CNT_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.raw_x_min     <= RAW_CALIB_MIN;
         cfg_ff.raw_x_max     <= RAW_CALIB_MAX;
         cfg_ff.raw_y_min     <= RAW_CALIB_MIN;
         cfg_ff.raw_y_max     <= RAW_CALIB_MAX;
         cfg_ff.screen_width  <= DEFAULT_WIDTH;
         cfg_ff.screen_height <= DEFAULT_HEIGHT;
         cfg_ff.avg_count     <= DEFAULT_AVG;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The sequencer owns the sample sums, the event state and the output
   // register, and issues every division to the one shared divider.
   tsam_core u_core (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pen_down    (req_pen_down),
      .req_x_byte_hi   (req_x_byte_hi),
      .req_x_byte_lo   (req_x_byte_lo),
      .req_y_byte_hi   (req_y_byte_hi),
      .req_y_byte_lo   (req_y_byte_lo),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_point_x     (rsp_point_x),
      .rsp_point_y     (rsp_point_y),
      .rsp_is_pressed  (rsp_is_pressed),
      .rsp_touch_event (rsp_touch_event),
      .div_req         (div_req),
      .div_rsp         (div_rsp)
   );

   tsam_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

endmodule

/* src/tsam_checker.sv */
`timescale 1ns / 1ps
`include "touch_sample_average_and_map_macros.svh"

module tsam_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_point_x,
   input logic [7:0] rsp_point_y,
   input logic       rsp_is_pressed,
   input logic [1:0] rsp_touch_event
);
   import tsam_pkg::*;

   logic [18:0] rsp_payload;
   logic        pressed_kind;

   assign rsp_payload  = {rsp_point_x, rsp_point_y, rsp_is_pressed, rsp_touch_event};
   assign pressed_kind = (rsp_touch_event == EV_PRESS) || (rsp_touch_event == EV_MOVE);

   // A blocked result stays put until it is taken.
   `TSAM_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))

   // No result is pending right after reset.
   `TSAM_ASSERT_SAME(a_rsp_after_reset, $past(reset), !rsp_valid)

   // Press and move come with the pressed flag, none and release without it.
   `TSAM_ASSERT_SAME(a_pressed_event, rsp_valid && rsp_is_pressed, pressed_kind)
   `TSAM_ASSERT_SAME(a_released_event, rsp_valid && !rsp_is_pressed, !pressed_kind)

   // While a result is blocked no new sample is taken.
   `TSAM_ASSERT_SAME(a_backpressure, rsp_valid && rsp_stall, req_stall)

endmodule

bind touch_sample_average_and_map tsam_checker u_tsam_checker (.*);

/* tb/sv/touch_sample_average_and_map_tb.sv */
`timescale 1ns / 1ps

// Self-checking bench for the touch averaging and mapping block.
// A driver pushes sample transfers from a queue and tracks the block in a
// predictor of its own. A monitor compares each result transfer with the
// oldest predicted point.
module touch_sample_average_and_map_tb;

   import tsam_pkg::*;

   // Pause after the last result, long enough for any divider pass still
   // running to finish before the registers are rewritten.
   localparam int SETTLE_CYCLES = 150;
   // Watchdog bound; the slowest correct run is a full average on every
   // transfer under the longest stalls.
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int PHASE_ITEMS   = 100;

   typedef struct {
      logic       pen_down;
      logic [7:0] x_hi;
      logic [7:0] x_lo;
      logic [7:0] y_hi;
      logic [7:0] y_lo;
      bit         hold_for_drain;
   } touch_sample_type;

   typedef struct {
      logic [7:0]      px;
      logic [7:0]      py;
      logic            pressed;
      touch_event_type ev;
   } screen_point_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_pen_down = 1'b0;
   logic [7:0]           req_x_byte_hi = 8'd0;
   logic [7:0]           req_x_byte_lo = 8'd0;
   logic [7:0]           req_y_byte_hi = 8'd0;
   logic [7:0]           req_y_byte_lo = 8'd0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [7:0]           rsp_point_x;
   logic [7:0]           rsp_point_y;
   logic                 rsp_is_pressed;
   logic [1:0]           rsp_touch_event;
   logic                 csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CODE_W-1:0]    csr_wdata = '0;

   touch_sample_type pending_samples[$];
   screen_point_type expected_points[$];
   touch_sample_type on_wire;
   screen_point_type expected_head;
   bit            sample_on_wire = 1'b0;
   bit            calm = 1'b0;
   int unsigned   gap_left = 0;
   int unsigned   stall_left = 0;
   int unsigned   sent_count = 0;
   int unsigned   checked_count = 0;
   int unsigned   failure_count = 0;
   int unsigned   setting_count = 0;
   int unsigned   cycle_count = 0;

   // Shadow of the register file and of the running state of the block.
   cfg_type       cfg_shadow;
   logic [15:0]   acc_x;
   logic [15:0]   acc_y;
   logic [3:0]    acc_n;
   logic [7:0]    last_px;
   logic [7:0]    last_py;
   bit            touching;

   touch_sample_average_and_map u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pen_down    (req_pen_down),
      .req_x_byte_hi   (req_x_byte_hi),
      .req_x_byte_lo   (req_x_byte_lo),
      .req_y_byte_hi   (req_y_byte_hi),
      .req_y_byte_lo   (req_y_byte_lo),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_point_x     (rsp_point_x),
      .rsp_point_y     (rsp_point_y),
      .rsp_is_pressed  (rsp_is_pressed),
      .rsp_touch_event (rsp_touch_event),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #6 clock = ~clock;

   // The converter delivers a left-aligned code: the top thirteen bits of the
   // sixteen bits formed by the two bytes.
   function automatic logic [12:0] raw_code(input logic [7:0] hi, input logic [7:0] lo);
      logic [15:0] word;
      word = {hi, lo};
      return word[15:3];
   endfunction

   // A count of zero behaves as one and anything above eight as eight.
   function automatic int unsigned avg_setting();
      int unsigned n;
      n = cfg_shadow.avg_count;
      if (n == 0) n = 1;
      if (n > 8) n = 8;
      return n;
   endfunction

   // Inverted mapping: the window minimum lands on the far edge (dim - 1) and
   // the maximum on zero. An empty window gives the far edge, a zero dimension
   // behaves as one, and anything past 255 saturates.
   function automatic logic [7:0] map_axis(input int unsigned v, input int unsigned lo,
                                           input int unsigned hi, input int unsigned dim);
      int unsigned top;
      int unsigned r;
      top = (dim == 0) ? 0 : dim - 1;
      if (hi <= lo) begin
         r = top;
      end else begin
         if (v < lo) v = lo;
         if (v > hi) v = hi;
         r = top - ((v - lo) * top) / (hi - lo);
      end
      return (r > 255) ? 8'd255 : r[7:0];
   endfunction

   // Advances the predictor by one accepted sample transfer and queues the
   // point that it causes, if any.
   task automatic absorb_sample(input touch_sample_type s);
      int unsigned      n;
      int unsigned      ax;
      int unsigned      ay;
      screen_point_type p;
      if (!s.pen_down) begin
         // Pen lifted: partial sums are thrown away and the last point is
         // reported as released, or as no event if nothing was pressed.
         acc_x = '0;
         acc_y = '0;
         acc_n = '0;
         p.ev = touching ? EV_RELEASE : EV_NONE;
         touching = 1'b0;
         p.px = last_px;
         p.py = last_py;
         p.pressed = 1'b0;
         expected_points.push_back(p);
      end else begin
         n = avg_setting();
         acc_x = acc_x + 16'(raw_code(s.x_hi, s.x_lo));
         acc_y = acc_y + 16'(raw_code(s.y_hi, s.y_lo));
         acc_n = acc_n + 4'd1;
         // Comparing against the current setting means a count lowered in
         // the middle of an average completes on the very next sample.
         if (acc_n >= n) begin
            ax = int'(acc_x) / int'(acc_n);
            ay = int'(acc_y) / int'(acc_n);
            acc_x = '0;
            acc_y = '0;
            acc_n = '0;
            // Axes are swapped: screen x follows raw y and screen y raw x.
            last_px = map_axis(ay, cfg_shadow.raw_y_min, cfg_shadow.raw_y_max,
                               cfg_shadow.screen_width);
            last_py = map_axis(ax, cfg_shadow.raw_x_min, cfg_shadow.raw_x_max,
                               cfg_shadow.screen_height);
            p.ev = touching ? EV_MOVE : EV_PRESS;
            touching = 1'b1;
            p.px = last_px;
            p.py = last_py;
            p.pressed = 1'b1;
            expected_points.push_back(p);
         end
      end
   endtask

   task automatic queue_sample(input logic pen, input logic [7:0] xh, input logic [7:0] xl,
                               input logic [7:0] yh, input logic [7:0] yl);
      touch_sample_type s;
      s.pen_down = pen;
      s.x_hi = xh;
      s.x_lo = xl;
      s.y_hi = yh;
      s.y_lo = yl;
      s.hold_for_drain = 1'b0;
      pending_samples.push_back(s);
   endtask

   // Packs two codes into converter bytes; the three bits below the code are
   // don't-care for the block and get random values.
   task automatic queue_codes(input logic pen, input logic [12:0] xc, input logic [12:0] yc);
      queue_sample(pen, xc[12:5], {xc[4:0], 3'($urandom_range(0, 7))},
                   yc[12:5], {yc[4:0], 3'($urandom_range(0, 7))});
   endtask

   task automatic queue_noise(input logic pen);
      queue_sample(pen, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
   endtask

   // Where a finger rests: mostly inside the window, sometimes anywhere, and
   // sometimes on the very ends of the code range.
   function automatic int unsigned pick_center(input int unsigned lo, input int unsigned hi);
      int unsigned sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) return 0;
      if (sel == 1) return 8191;
      if (sel == 2 || hi <= lo) return $urandom_range(0, 8191);
      return $urandom_range(lo, hi);
   endfunction

   function automatic logic [12:0] near_code(input int unsigned center);
      int v;
      v = int'(center) + int'($urandom_range(0, 64)) - 32;
      if (v < 0) v = 0;
      if (v > 8191) v = 8191;
      return 13'(v);
   endfunction

   // Most of the traffic is whole strokes: pen-down runs that fill one or
   // more averages, closed by a pen-up. The rest is strokes cut short and
   // plain noise, which may leave partial sums behind for the next stroke.
   task automatic fill_random_phase(input int unsigned count);
      int unsigned made;
      int unsigned n;
      int unsigned kind;
      int unsigned len;
      int unsigned cx;
      int unsigned cy;
      made = 0;
      n = avg_setting();
      while (made < count) begin
         kind = $urandom_range(0, 9);
         cx = pick_center(cfg_shadow.raw_x_min, cfg_shadow.raw_x_max);
         cy = pick_center(cfg_shadow.raw_y_min, cfg_shadow.raw_y_max);
         if (kind < 6) begin
            len = n * $urandom_range(1, 3);
         end else if (kind < 8) begin
            len = (n > 1) ? $urandom_range(1, n - 1) : 0;
         end else begin
            len = 0;
         end
         for (int k = 0; k < len; k++) begin
            queue_codes(1'b1, near_code(cx), near_code(cy));
         end
         queue_noise(kind >= 8 ? 1'($urandom_range(0, 1)) : 1'b0);
         made += len + 1;
      end
      // One transfer in the phase waits until the block has gone quiet.
      pending_samples[$urandom_range(0, pending_samples.size() - 1)].hold_for_drain = 1'b1;
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [12:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_RAW_X_MIN:     cfg_shadow.raw_x_min = value;
         CSR_RAW_X_MAX:     cfg_shadow.raw_x_max = value;
         CSR_RAW_Y_MIN:     cfg_shadow.raw_y_min = value;
         CSR_RAW_Y_MAX:     cfg_shadow.raw_y_max = value;
         CSR_SCREEN_WIDTH:  cfg_shadow.screen_width = value[8:0];
         CSR_SCREEN_HEIGHT: cfg_shadow.screen_height = value[8:0];
         CSR_AVG_COUNT:     cfg_shadow.avg_count = value[3:0];
         default: ;
      endcase
   endtask

   task automatic end_writes();
      @(posedge clock);
      csr_write_en <= 1'b0;
      setting_count++;
   endtask

   task automatic program_all(input int unsigned xmin, input int unsigned xmax,
                              input int unsigned ymin, input int unsigned ymax,
                              input int unsigned w, input int unsigned h,
                              input int unsigned avg);
      write_reg(CSR_RAW_X_MIN, 13'(xmin));
      write_reg(CSR_RAW_X_MAX, 13'(xmax));
      write_reg(CSR_RAW_Y_MIN, 13'(ymin));
      write_reg(CSR_RAW_Y_MAX, 13'(ymax));
      write_reg(CSR_SCREEN_WIDTH, 13'(w));
      write_reg(CSR_SCREEN_HEIGHT, 13'(h));
      write_reg(CSR_AVG_COUNT, 13'(avg));
      end_writes();
   endtask

   // Waits until every queued transfer has gone in and every predicted point
   // has come out, then gives the divider time to finish anything in flight.
   task automatic settle();
      while (pending_samples.size() != 0 || sample_on_wire || expected_points.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic note_failure(input string msg);
      failure_count++;
      if (failure_count <= 10) $display("MISMATCH: %s", msg);
   endtask

   // Driver. A payload stays put while it is stalled. After each transfer a
   // random gap follows, except in calm phases.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            absorb_sample(on_wire);
            sample_on_wire = 1'b0;
            sent_count++;
         end
         if (!(req_valid && req_stall)) begin
            if (gap_left != 0) begin
               req_valid <= 1'b0;
               gap_left--;
            end else if (pending_samples.size() != 0 &&
                         !(pending_samples[0].hold_for_drain && expected_points.size() != 0)) begin
               on_wire = pending_samples.pop_front();
               sample_on_wire = 1'b1;
               req_valid <= 1'b1;
               req_pen_down <= on_wire.pen_down;
               req_x_byte_hi <= on_wire.x_hi;
               req_x_byte_lo <= on_wire.x_lo;
               req_y_byte_hi <= on_wire.y_hi;
               req_y_byte_lo <= on_wire.y_lo;
               gap_left = calm ? 0 : $urandom_range(0, 7);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor. The stall is raised at random on each offered result; while nothing
   // is offered it also toggles at random, so it lands on every phase of the
   // block's work.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_points.size() == 0) begin
               note_failure($sformatf("unexpected result x=%0d y=%0d pressed=%0d event=%0d",
                                      rsp_point_x, rsp_point_y, rsp_is_pressed,
                                      rsp_touch_event));
            end else begin
               expected_head = expected_points.pop_front();
               if (rsp_point_x !== expected_head.px || rsp_point_y !== expected_head.py ||
                   rsp_is_pressed !== expected_head.pressed ||
                   rsp_touch_event !== 2'(expected_head.ev)) begin
                  note_failure($sformatf(
                     {"result %0d: expected x=%0d y=%0d pressed=%0d event=%0d, ",
                      "got x=%0d y=%0d pressed=%0d event=%0d"},
                     checked_count, expected_head.px, expected_head.py, expected_head.pressed,
                     expected_head.ev, rsp_point_x, rsp_point_y, rsp_is_pressed,
                     rsp_touch_event));
               end
               checked_count++;
            end
            stall_left = calm ? 0 : $urandom_range(0, 7);
         end
         if (rsp_valid && stall_left != 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= !calm && !rsp_valid && ($urandom_range(0, 3) == 0);
         end
      end
   end

   // Watchdog: a lost result or a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      cfg_shadow.raw_x_min = RAW_CALIB_MIN;
      cfg_shadow.raw_x_max = RAW_CALIB_MAX;
      cfg_shadow.raw_y_min = RAW_CALIB_MIN;
      cfg_shadow.raw_y_max = RAW_CALIB_MAX;
      cfg_shadow.screen_width = DEFAULT_WIDTH;
      cfg_shadow.screen_height = DEFAULT_HEIGHT;
      cfg_shadow.avg_count = DEFAULT_AVG;
      acc_x = '0;
      acc_y = '0;
      acc_n = '0;
      last_px = '0;
      last_py = '0;
      touching = 1'b0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset calibration (six pairs per point).
      // A pen-up before any touch reports no event at the origin.
      queue_sample(1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
      // First average: all-ones and all-zero bytes on both axes, then the
      // window edges and the code extremes; it reports a press.
      queue_sample(1'b1, 8'hFF, 8'hFF, 8'h00, 8'h00);
      queue_sample(1'b1, 8'h00, 8'h00, 8'hFF, 8'hFF);
      queue_codes(1'b1, 13'd300, 13'd3800);
      queue_codes(1'b1, 13'd3800, 13'd300);
      queue_codes(1'b1, 13'd8191, 13'd0);
      queue_codes(1'b1, 13'd0, 13'd8191);
      // Second average, pinned below and above the window; it reports a move.
      for (int k = 0; k < 3; k++) queue_codes(1'b1, 13'd100, 13'd5000);
      for (int k = 0; k < 3; k++) queue_codes(1'b1, 13'd250, 13'd4000);
      // Release, then a second pen-up that reports no event.
      queue_noise(1'b0);
      queue_noise(1'b0);
      // A partial average is dropped by the pen-up; the next six pairs alone
      // make the following press.
      for (int k = 0; k < 3; k++) queue_codes(1'b1, 13'd8191, 13'd8191);
      queue_noise(1'b0);
      for (int k = 0; k < 6; k++) queue_codes(1'b1, 13'd2000 + 13'(k * 97), 13'd1500);
      settle();

      // Widest window and the largest screen that fits the 8-bit output, one pair per point.
      program_all(0, 8191, 0, 8191, 256, 256, 1);
      fill_random_phase(PHASE_ITEMS);
      settle();

      // Longest average onto a one-pixel screen.
      program_all(300, 3800, 300, 3800, 1, 1, 8);
      fill_random_phase(PHASE_ITEMS);
      settle();

      // Inverted and collapsed windows, zero dimensions and a zero count.
      program_all(5000, 4000, 2000, 2000, 0, 0, 0);
      fill_random_phase(PHASE_ITEMS);
      settle();

      // Narrow window, oversized screen that saturates, count above eight.
      program_all(1000, 1010, 7000, 8191, 511, 300, 15);
      fill_random_phase(PHASE_ITEMS);
      settle();

      // A calm stretch: no gaps and no stalls on either side.
      calm = 1'b1;
      program_all($urandom_range(0, 3000), $urandom_range(3000, 8191), $urandom_range(0, 3000),
                  $urandom_range(3000, 8191), $urandom_range(1, 256), $urandom_range(1, 256), 3);
      fill_random_phase(PHASE_ITEMS);
      settle();
      calm = 1'b0;

      // Lower the count in the middle of an average: five of eight pairs are
      // held, and with a setting of three the next pair completes the point.
      program_all(300, 3800, 300, 3800, 160, 128, 8);
      queue_noise(1'b0);
      for (int k = 0; k < 5; k++) queue_codes(1'b1, 13'd1200 + 13'(k * 311), 13'd3000);
      settle();
      write_reg(CSR_AVG_COUNT, 13'd3);
      end_writes();
      queue_codes(1'b1, 13'd1700, 13'd2900);
      fill_random_phase(PHASE_ITEMS);
      settle();

      // Random calibrations, with the maximum sometimes below the minimum.
      for (int p = 0; p < 3; p++) begin
         program_all($urandom_range(0, 4000), $urandom_range(0, 8191), $urandom_range(0, 4000),
                     $urandom_range(0, 8191), $urandom_range(1, 256), $urandom_range(1, 256),
                     $urandom_range(1, 8));
         fill_random_phase(PHASE_ITEMS);
         settle();
      end

      $display("Sent %0d sample transfers and checked %0d results over %0d register settings,",
               sent_count, checked_count, setting_count + 1);
      $display("including empty windows, zero and oversized counts and screen sizes.");
      if (failure_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+src
src/tsam_pkg.sv
src/tsam_div.sv
src/tsam_core.sv
src/touch_sample_average_and_map.sv
src/tsam_checker.sv
tb/sv/touch_sample_average_and_map_tb.sv
